/* src/ptm_pkg.sv */
// ---------------------------------------------------------------------------
// Pulse channel tick mixer package
// Widths, register indexes, divider request types and sign helpers shared
// by the mixer top level and its divider.
// ---------------------------------------------------------------------------
package ptm_pkg;

   localparam int ACC_BITS      = 48;
   localparam int TICK_BITS     = 16;
   localparam int OUT_BITS      = 48;
   localparam int LEVEL_BITS    = 16;
   localparam int DIV_BITS      = 16;
   localparam int PERIOD_BITS   = 12;
   localparam int PCNT_BITS     = PERIOD_BITS + 1;
   localparam int DUTY_BITS     = 4;
   localparam int CNT_BITS      = $clog2(ACC_BITS);
   localparam int PROD_BITS     = LEVEL_BITS + PCNT_BITS;
   localparam int CMP_BITS      = (TICK_BITS > PCNT_BITS) ? TICK_BITS : PCNT_BITS;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 2 * OUT_BITS;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic KIND_TICK_RUN = 1'b0;
   localparam logic KIND_READOUT  = 1'b1;

   localparam logic [DUTY_BITS-1:0] INVERT_STEP = 4'd10;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_CHANNEL_ENABLE = 3'd0,
      REG_DUTY_THRESHOLD = 3'd1,
      REG_DIGITIZED_MODE = 3'd2,
      REG_PERIOD         = 3'd3,
      REG_INVERT_ENABLE  = 3'd4,
      REG_INVERT_CUTOFF  = 3'd5,
      REG_LEVEL_LEFT     = 3'd6,
      REG_LEVEL_RIGHT    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic                start;
      logic [ACC_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [ACC_BITS-1:0] quotient;
   } div_rsp_type;

   // absolute value of a two's complement accumulator
   function automatic logic [ACC_BITS-1:0] acc_magnitude(input logic [ACC_BITS-1:0] acc);
      logic [ACC_BITS-1:0] mag;
      mag = acc[ACC_BITS-1] ? (~acc + ACC_BITS'(1)) : acc;
      return mag;
   endfunction

   // reapply the sign and fit the quotient to the output width
   function automatic logic [OUT_BITS-1:0] signed_out(input logic neg,
                                                      input logic [ACC_BITS-1:0] quo);
      logic [ACC_BITS-1:0] val;
      val = neg ? (~quo + ACC_BITS'(1)) : quo;
      return OUT_BITS'(signed'(val));
   endfunction

endpackage

/* src/ptm_divider.sv */
// ---------------------------------------------------------------------------
// Pulse channel tick mixer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ptm_divider
   import ptm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [ACC_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] div_ff, div_in;
   logic [DIV_BITS:0]   shifted;
   logic [DIV_BITS:0]   diff;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[ACC_BITS-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = (shifted >= {1'b0, div_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(ACC_BITS - 1);
         quo_in   = div_req.dividend;
         rem_in   = '0;
         div_in   = div_req.divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[ACC_BITS-2:0], fits};
         rem_in   = fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* src/pulse_channel_tick_mixer_unit.sv */
// ---------------------------------------------------------------------------
// Pulse channel tick mixer
// Pulse voice with a period down-counter and duty step; tick runs mix the
// channel output into two accumulators, readouts return them divided and clear them.
// ---------------------------------------------------------------------------
// Tick run: each reload stretch passes ST_SEG and ST_RELOAD, with ST_MUL_L, ST_ADD_L
//   and ST_ADD_R between them when mixing; a disabled channel or zero ticks is dropped.
// Readout: the shared one-bit-per-cycle divider handles left then right; the result
//   sits in an output register so a tick run can be taken while it waits.
// Reset clears the control registers, the accumulators, duty step and invert flag;
//   the period counter resets to one; datapath registers are not reset.
module pulse_channel_tick_mixer_unit
   import ptm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // ticks[15:0], mix_enable, divisor[15:0], pad
   input  logic                     req_tuser,  // kind
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // mix_left[47:0], mix_right[47:0]
   // register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SEG    = 9'b000000010,
      ST_MUL_L  = 9'b000000100,
      ST_ADD_L  = 9'b000001000,
      ST_ADD_R  = 9'b000010000,
      ST_RELOAD = 9'b000100000,
      ST_DIV_L  = 9'b001000000,
      ST_DIV_R  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   // registers
   logic                   chan_en_ff;
   logic [DUTY_BITS-1:0]   duty_thr_ff;
   logic                   digitized_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic                   inv_en_ff;
   logic [PERIOD_BITS-1:0] inv_cutoff_ff;
   logic [LEVEL_BITS-1:0]  level_l_ff;
   logic [LEVEL_BITS-1:0]  level_r_ff;

   state_type              state_ff, state_in;
   logic [PCNT_BITS-1:0]   pcnt_ff, pcnt_in;
   logic [DUTY_BITS-1:0]   duty_ff, duty_in;
   logic                   invert_ff, invert_in;
   logic [ACC_BITS-1:0]    acc_l_ff, acc_l_in;
   logic [ACC_BITS-1:0]    acc_r_ff, acc_r_in;
   logic [TICK_BITS-1:0]   ticks_ff, ticks_in;
   logic                   mix_ff, mix_in;
   logic [PCNT_BITS-1:0]   n_ff, n_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [DIV_BITS-1:0]    div_ff, div_in;
   logic                   neg_l_ff, neg_l_in;
   logic                   neg_r_ff, neg_r_in;
   logic [OUT_BITS-1:0]    out_l_ff, out_l_in;
   logic [OUT_BITS-1:0]    out_r_ff, out_r_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   div_req_type            div_req;
   div_rsp_type            div_rsp;

   logic [TICK_BITS-1:0]   req_ticks;
   logic                   req_mix;
   logic [DIV_BITS-1:0]    req_div;
   logic                   req_fire;
   logic [CMP_BITS-1:0]    pcnt_wide;
   logic [CMP_BITS-1:0]    ticks_wide;
   logic [DUTY_BITS-1:0]   duty_next;
   logic                   latch_val;
   logic [PROD_BITS-1:0]   mul_in_a;

   assign req_ticks = TICK_BITS'(req_tdata[15:0]);
   assign req_mix   = req_tdata[16];
   assign req_div   = req_tdata[32:17];
   assign req_fire  = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pcnt_wide  = CMP_BITS'(pcnt_ff);
   assign ticks_wide = CMP_BITS'(ticks_ff);
   assign duty_next  = duty_ff + DUTY_BITS'(1);
   assign latch_val  = (inv_cutoff_ff < period_ff) ? 1'b0 : inv_en_ff;

   // shared multiplier: left level first, right level on the next pass
   assign mul_in_a   = (state_ff == ST_MUL_L) ? PROD_BITS'(level_l_ff) : PROD_BITS'(level_r_ff);

   always_comb begin
      state_in     = state_ff;
      pcnt_in      = pcnt_ff;
      duty_in      = duty_ff;
      invert_in    = invert_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      ticks_in     = ticks_ff;
      mix_in       = mix_ff;
      n_in         = n_ff;
      prod_in      = prod_ff;
      div_in       = div_ff;
      neg_l_in     = neg_l_ff;
      neg_r_in     = neg_r_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_READOUT) begin
                  div_in           = (req_div == '0) ? DIV_BITS'(1) : req_div;
                  neg_l_in         = acc_l_ff[ACC_BITS-1];
                  div_req.start    = 1'b1;
                  div_req.dividend = acc_magnitude(acc_l_ff);
                  div_req.divisor  = (req_div == '0) ? DIV_BITS'(1) : req_div;
                  state_in         = ST_DIV_L;
               end else if (chan_en_ff && (req_ticks != '0)) begin
                  ticks_in = req_ticks;
                  mix_in   = req_mix;
                  state_in = ST_SEG;
               end
            end
         end
         ST_SEG: begin
            // run to the next reload or to the end of the ticks
            if (pcnt_wide < ticks_wide) begin
               n_in = pcnt_ff;
            end else begin
               n_in = PCNT_BITS'(ticks_ff);
            end
            ticks_in = TICK_BITS'(ticks_wide - CMP_BITS'(n_in));
            pcnt_in  = pcnt_ff - n_in;
            state_in = (mix_ff && (duty_ff <= duty_thr_ff)) ? ST_MUL_L : ST_RELOAD;
         end
         ST_MUL_L: begin
            prod_in  = PROD_BITS'(mul_in_a * PROD_BITS'(n_ff));
            state_in = ST_ADD_L;
         end
         ST_ADD_L: begin
            acc_l_in = acc_l_ff + ACC_BITS'(prod_ff);
            prod_in  = PROD_BITS'(mul_in_a * PROD_BITS'(n_ff));
            state_in = ST_ADD_R;
         end
         ST_ADD_R: begin
            if (invert_ff) begin
               acc_r_in = acc_r_ff - ACC_BITS'(prod_ff);
            end else begin
               acc_r_in = acc_r_ff + ACC_BITS'(prod_ff);
            end
            state_in = ST_RELOAD;
         end
         ST_RELOAD: begin
            if (pcnt_ff == '0) begin
               pcnt_in = PCNT_BITS'(period_ff) + PCNT_BITS'(1);
               if (!digitized_ff) begin
                  duty_in = duty_next;
                  if (duty_next == INVERT_STEP) begin
                     invert_in = latch_val;
                  end
               end else begin
                  invert_in = latch_val;
               end
            end
            state_in = (ticks_ff == '0) ? ST_IDLE : ST_SEG;
         end
         ST_DIV_L: begin
            if (div_rsp.done) begin
               out_l_in         = signed_out(neg_l_ff, div_rsp.quotient);
               neg_r_in         = acc_r_ff[ACC_BITS-1];
               div_req.start    = 1'b1;
               div_req.dividend = acc_magnitude(acc_r_ff);
               div_req.divisor  = div_ff;
               acc_l_in         = '0;
               acc_r_in         = '0;
               state_in         = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            if (div_rsp.done) begin
               out_r_in = signed_out(neg_r_ff, div_rsp.quotient);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {out_r_ff, out_l_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_en_ff    <= 1'b0;
         duty_thr_ff   <= '0;
         digitized_ff  <= 1'b0;
         period_ff     <= '0;
         inv_en_ff     <= 1'b0;
         inv_cutoff_ff <= '0;
         level_l_ff    <= '0;
         level_r_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_CHANNEL_ENABLE: chan_en_ff    <= csr_data[0];
            REG_DUTY_THRESHOLD: duty_thr_ff   <= csr_data[DUTY_BITS-1:0];
            REG_DIGITIZED_MODE: digitized_ff  <= csr_data[0];
            REG_PERIOD:         period_ff     <= csr_data[PERIOD_BITS-1:0];
            REG_INVERT_ENABLE:  inv_en_ff     <= csr_data[0];
            REG_INVERT_CUTOFF:  inv_cutoff_ff <= csr_data[PERIOD_BITS-1:0];
            REG_LEVEL_LEFT:     level_l_ff    <= csr_data[LEVEL_BITS-1:0];
            REG_LEVEL_RIGHT:    level_r_ff    <= csr_data[LEVEL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcnt_ff      <= PCNT_BITS'(1);
         duty_ff      <= '0;
         invert_ff    <= 1'b0;
         acc_l_ff     <= '0;
         acc_r_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcnt_ff      <= pcnt_in;
         duty_ff      <= duty_in;
         invert_ff    <= invert_in;
         acc_l_ff     <= acc_l_in;
         acc_r_ff     <= acc_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ticks_ff    <= ticks_in;
      mix_ff      <= mix_in;
      n_ff        <= n_in;
      prod_ff     <= prod_in;
      div_ff      <= div_in;
      neg_l_ff    <= neg_l_in;
      neg_r_ff    <= neg_r_in;
      out_l_ff    <= out_l_in;
      out_r_ff    <= out_r_in;
      rsp_data_ff <= rsp_data_in;
   end

   ptm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
